// File: rtl/srl_pkg.sv
package srl_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int ADDR_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);

    localparam int IDX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int TYPE_W  = 4;
    localparam int CFG_W   = 32;
    localparam int ECNT_W  = 9;
    localparam int S_DATA_W = 144;

    localparam logic [TYPE_W-1:0] MATCH_TYPE = 4'h2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_STR_BASE    = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
        logic [TYPE_W-1:0] etype;
        logic [WORD_W-1:0] name_offset;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              load_query;
        logic              out_load;
        logic              out_found;
    } t_dp_cmd;

    typedef struct packed {
        logic             hit;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

// File: rtl/symbol_range_lookup_unit.sv
// Channel   Direction  Ports                          Item
// s         in         i_s_tvalid/o_s_tready          write or lookup item
// m         out        o_m_tvalid/i_m_tready          lookup result
// cfg       in         i_cfg_we/i_cfg_index           entry_count, string_table_base
//
// A lookup reads the table store one entry a cycle through its single
// registered read port, over at most MAX_SYMBOLS entries, up to the first hit.
// Synchronous active-low reset clears control and configuration only; the
// table needs no clearing pass. A stalled result holds in the output register,
// which also frees the input side once the result is loaded.
module symbol_range_lookup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [srl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] entry_index, [39:8] entry_start, [71:40] entry_size,
    // [75:72] entry_type, [107:76] entry_name_offset, [139:108] query_address
    input  logic [srl_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] opcode
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] name_address
    output logic [srl_pkg::WORD_W-1:0]    o_m_tdata,
    // [0] found
    output logic                          o_m_tuser
);
    import srl_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    srl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// File: rtl/srl_dpath.sv
module srl_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [srl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [srl_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  srl_pkg::t_dp_cmd              i_cmd,
    output srl_pkg::t_dp_stat             o_stat,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [srl_pkg::WORD_W-1:0]    o_m_tdata,
    output logic                          o_m_tuser
);
    import srl_pkg::*;

    logic [ECNT_W-1:0] r_entry_count;
    logic [WORD_W-1:0] r_str_base;
    logic [WORD_W-1:0] r_query;
    t_entry            r_mem [MAX_SYMBOLS];
    t_entry            r_rd_data;
    logic              r_out_valid;
    logic              r_out_found;
    logic [WORD_W-1:0] r_out_name;

    logic [IDX_W-1:0]  w_idx;
    t_entry            w_entry;
    logic              w_idx_ok;
    logic [WORD_W:0]   w_end;
    logic [WORD_W-1:0] w_name;

    assign w_idx               = i_s_tdata[7:0];
    assign w_entry.start       = i_s_tdata[39:8];
    assign w_entry.size        = i_s_tdata[71:40];
    assign w_entry.etype       = i_s_tdata[75:72];
    assign w_entry.name_offset = i_s_tdata[107:76];
    assign w_idx_ok            = (32'(w_idx) < MAX_SYMBOLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_str_base    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[ECNT_W-1:0];
                CFG_STR_BASE:    r_str_base    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // table store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_idx_ok) begin
            r_mem[ADDR_W'(w_idx)] <= w_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_query <= i_s_tdata[139:108];
        end
    end

    // range end in one bit more so it never wraps
    assign w_end = {1'b0, r_rd_data.start} + {1'b0, r_rd_data.size};
    assign w_name = r_str_base + r_rd_data.name_offset;

    always_comb begin
        o_stat.hit      = (r_rd_data.etype == MATCH_TYPE) &&
                          (r_query >= r_rd_data.start) &&
                          ({1'b0, r_query} < w_end);
        o_stat.out_free = !r_out_valid || i_m_tready;
        o_stat.count    = (32'(r_entry_count) > MAX_SYMBOLS) ?
                          CNT_W'(MAX_SYMBOLS) : CNT_W'(r_entry_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= i_cmd.out_found;
            r_out_name  <= i_cmd.out_found ? w_name : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_name;
    assign o_m_tuser  = r_out_found;

endmodule

// File: rtl/srl_ctrl.sv
module srl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tuser,
    output logic               o_s_tready,
    input  srl_pkg::t_dp_stat  i_stat,
    output srl_pkg::t_dp_cmd   o_cmd
);
    import srl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_dval, n_dval;

    logic w_accept;
    logic w_hit;
    logic w_miss;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_hit      = r_dval && i_stat.hit;
    // all reads issued and the last one did not hit
    assign w_miss     = (r_idx == r_n) && !w_hit;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_dval  = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_addr = ADDR_W'(r_idx);
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == OP_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_idx   = '0;
                        n_n     = i_stat.count;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = (r_idx != r_n) && !w_hit;
                n_dval      = o_cmd.rd_en;
                n_idx       = r_idx + CNT_W'(o_cmd.rd_en);
                if (w_hit || w_miss) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_found = w_hit;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = w_hit ? ST_HIT : ST_MISS;
                    end
                end
            end
            ST_HIT, ST_MISS: begin
                // hold the last read entry until the output register frees
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = (r_state == ST_HIT);
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_n     <= '0;
            r_dval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_dval  <= n_dval;
        end
    end

endmodule

// File: bench/tb_symbol_range_lookup_unit.sv
module tb_symbol_range_lookup_unit;
    import srl_pkg::*;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
        logic [TYPE_W-1:0] etype;
        logic [WORD_W-1:0] name_off;
        logic [WORD_W-1:0] query;
    } t_sym_item;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] name_addr;
    } t_name_hit;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [WORD_W-1:0]   o_m_tdata;
    logic                o_m_tuser;

    // Local copy of the symbol table and registers
    logic [WORD_W-1:0] sym_start [MAX_SYMBOLS];
    logic [WORD_W-1:0] sym_size  [MAX_SYMBOLS];
    logic [TYPE_W-1:0] sym_type  [MAX_SYMBOLS];
    logic [WORD_W-1:0] sym_name  [MAX_SYMBOLS];
    logic [ECNT_W-1:0] scan_count;
    logic [WORD_W-1:0] str_base;

    t_sym_item item_fifo[$];
    t_name_hit expected_names[$];
    bit        s_offered;
    bit        idle_en;
    int        errors;

    symbol_range_lookup_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // First type 2 entry in scan order whose range holds the address
    function automatic t_name_hit resolve_symbol(logic [WORD_W-1:0] addr);
        t_name_hit res;
        int        n;
        logic [WORD_W:0] lo;
        logic [WORD_W:0] hi;
        res = '0;
        n = (scan_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(scan_count);
        for (int i = 0; i < n; i++) begin
            lo = {1'b0, sym_start[i]};
            hi = lo + {1'b0, sym_size[i]};
            if (!res.found && sym_type[i] == MATCH_TYPE && {1'b0, addr} >= lo
                && {1'b0, addr} < hi) begin
                res.found     = 1'b1;
                res.name_addr = str_base + sym_name[i];
            end
        end
        return res;
    endfunction

    function automatic t_sym_item make_entry(logic [IDX_W-1:0] idx);
        t_sym_item it;
        it.op       = OP_WRITE;
        it.idx      = idx;
        it.start    = $urandom();
        it.etype    = ($urandom_range(99) < 55) ? MATCH_TYPE : TYPE_W'($urandom_range(15));
        it.name_off = $urandom();
        it.query    = $urandom();
        case ($urandom_range(9))
            0: it.size = '0;
            1, 2, 3: it.size = $urandom_range(64, 1);
            4, 5: it.size = $urandom_range(65535, 1);
            6: begin
                // straddle the top of the address space
                it.start = 32'hFFFF_FFFF - $urandom_range(255);
                it.size  = $urandom_range(4096, 1);
            end
            7: it.size = 32'hFFFF_FFFF;
            8: begin
                // cluster starts so that ranges overlap
                it.start = 32'h0001_0000 + $urandom_range(4095);
                it.size  = $urandom_range(512, 1);
            end
            default: it.size = $urandom();
        endcase
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] pick_query();
        int n;
        int k;
        int sel;
        logic [WORD_W:0]   hi;
        logic [WORD_W-1:0] off;
        n = (scan_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(scan_count);
        sel = $urandom_range(99);
        if (n == 0 || sel < 15)
            return $urandom();
        k = $urandom_range(n - 1);
        for (int t = 0; t < 4; t++) begin
            if (sym_type[k] != MATCH_TYPE)
                k = $urandom_range(n - 1);
        end
        hi = {1'b0, sym_start[k]} + {1'b0, sym_size[k]};
        if (sel < 27)
            return hi[WORD_W-1:0];
        if (sel < 37)
            return sym_start[k];
        if (sel < 47)
            return hi[WORD_W-1:0] - 1;
        if (sym_size[k] == 0)
            return sym_start[k];
        off = $urandom();
        return sym_start[k] + (off % sym_size[k]);
    endfunction

    function automatic t_sym_item make_random_item();
        t_sym_item it;
        int n;
        n = (scan_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(scan_count);
        if ($urandom_range(99) < 35) begin
            // mostly rewrite entries inside the scanned part
            if (n > 0 && $urandom_range(99) < 70)
                it = make_entry(IDX_W'($urandom_range(n - 1)));
            else
                it = make_entry(IDX_W'($urandom_range(MAX_SYMBOLS - 1)));
        end else begin
            it          = make_entry(IDX_W'($urandom_range(MAX_SYMBOLS - 1)));
            it.op       = OP_LOOKUP;
            it.query    = pick_query();
        end
        return it;
    endfunction

    task automatic note_error(string what, t_name_hit want, logic found, logic [WORD_W-1:0] addr);
        if (errors < 10)
            $display("%0t: %s: expected found=%0b name=%h, got found=%0b name=%h",
                     $realtime, what, want.found, want.name_addr, found, addr);
        errors++;
    endtask

    task automatic send_item(t_sym_item it);
        item_fifo.push_back(it);
        while (item_fifo.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_ENTRY_COUNT)
            scan_count = val[ECNT_W-1:0];
        else
            str_base = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait for every result, then idle for extra_cycles more clocks
    task automatic drain_results(int extra_cycles);
        while (item_fifo.size() != 0 || expected_names.size() != 0)
            @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        t_sym_item it;
        it = make_entry('0);
        it.op    = OP_LOOKUP;
        it.query = '0;
        send_item(it);
        it.query = 32'hFFFF_FFFF;
        send_item(it);
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < MAX_SYMBOLS; i++)
            send_item(make_entry(IDX_W'(i)));
    endtask

    task automatic test_directed();
        t_sym_item it;
        logic [WORD_W-1:0] queries [9];
        queries = '{32'h0000_1000, 32'h0000_100F, 32'h0000_1010, 32'h0000_10FF,
                    32'h0000_1100, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0000_2005, 32'h0};
        it = make_entry('0);
        // wrong type, covers all but the top address: skip
        it.etype = 4'hF; it.start = '0; it.size = 32'hFFFF_FFFF; it.name_off = 32'h1;
        send_item(it);
        // empty range
        it.idx = 1; it.etype = MATCH_TYPE; it.start = 32'h1000; it.size = '0;
        it.name_off = 32'h11;
        send_item(it);
        // range end beyond 32 bits
        it.idx = 2; it.start = 32'hFFFF_FF00; it.size = 32'h200; it.name_off = 32'hFFFF_FFFF;
        send_item(it);
        // overlapping pair: first in scan order wins
        it.idx = 3; it.start = 32'h1000; it.size = 32'h10; it.name_off = 32'h30;
        send_item(it);
        it.idx = 4; it.size = 32'h100; it.name_off = 32'h40;
        send_item(it);
        it.idx = 5; it.etype = 4'h0; it.start = 32'h2000; it.size = 32'h10;
        send_item(it);
        it.idx = 6; it.etype = MATCH_TYPE; it.start = '0; it.size = 32'hFFFF_FFFF;
        it.name_off = 32'h60;
        send_item(it);
        it.idx = 8'hFF; it.start = 32'h7000_0000; it.size = 32'h1; it.name_off = 32'hABCD;
        send_item(it);
        drain_results(MAX_SYMBOLS + 4);
        write_reg(CFG_ENTRY_COUNT, 7);
        write_reg(CFG_STR_BASE, 32'hFFFF_FFF0);
        it.op = OP_LOOKUP;
        foreach (queries[q]) begin
            it.query = queries[q];
            send_item(it);
        end
        drain_results(MAX_SYMBOLS + 4);
        write_reg(CFG_ENTRY_COUNT, 1);
        it.query = 32'h1234;
        send_item(it);
        drain_results(MAX_SYMBOLS + 4);
        // count above the table saturates
        write_reg(CFG_ENTRY_COUNT, 32'h1FF);
        it.query = 32'hFFFF_FFFF;
        send_item(it);
        it.query = 32'h7000_0000;
        send_item(it);
        drain_results(MAX_SYMBOLS + 4);
    endtask

    task automatic test_random_phases();
        int counts [10];
        logic [WORD_W-1:0] bases [10];
        counts = '{16, 256, 1, 5, 255, 40, 0, 511, 3, 100};
        bases  = '{$urandom(), 32'h0, 32'hFFFF_FFFF, $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        foreach (counts[p]) begin
            write_reg(CFG_ENTRY_COUNT, counts[p]);
            write_reg(CFG_STR_BASE, bases[p]);
            for (int i = 0; i < 90; i++) begin
                if (i == 45)
                    drain_results(0);
                send_item(make_random_item());
            end
            drain_results(MAX_SYMBOLS + 4);
        end
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        write_reg(CFG_ENTRY_COUNT, 12);
        write_reg(CFG_STR_BASE, $urandom());
        for (int i = 0; i < 100; i++)
            send_item(make_random_item());
        drain_results(MAX_SYMBOLS + 4);
        idle_en = 1'b1;
    endtask

    // Sender: hold an offered item until taken, idle at random between items while idle_en is set
    always @(negedge i_clk) begin : drive_items
        t_sym_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!s_offered) begin
            if (item_fifo.size() != 0 && !(idle_en && $urandom_range(99) < 37)) begin
                nxt = item_fifo[0];
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= nxt.op;
                i_s_tdata  <= {4'b0, nxt.query, nxt.name_off, nxt.etype, nxt.size,
                               nxt.start, nxt.idx};
                s_offered  = 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n)
            i_m_tready <= !idle_en || ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin : watch_ports
        t_sym_item cur;
        t_name_hit want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_names.size() == 0) begin
                    note_error("unexpected result", '0, o_m_tuser, o_m_tdata);
                end else begin
                    want = expected_names.pop_front();
                    if (o_m_tuser !== want.found || o_m_tdata !== want.name_addr)
                        note_error("result mismatch", want, o_m_tuser, o_m_tdata);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                cur = item_fifo.pop_front();
                s_offered = 1'b0;
                if (cur.op == OP_WRITE) begin
                    sym_start[cur.idx] = cur.start;
                    sym_size[cur.idx]  = cur.size;
                    sym_type[cur.idx]  = cur.etype;
                    sym_name[cur.idx]  = cur.name_off;
                end else begin
                    expected_names.push_back(resolve_symbol(cur.query));
                end
            end
        end
    end

    initial begin
        #36_000_000;
        $display("symbol_range_lookup_unit verification failed");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_ENTRY_COUNT;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_WRITE;
        i_m_tready  = 1'b0;
        scan_count  = '0;
        str_base    = '0;
        s_offered   = 1'b0;
        idle_en     = 1'b1;
        errors      = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_table();
        test_directed();
        test_random_phases();
        test_back_to_back();

        drain_results(MAX_SYMBOLS + 4);
        if (expected_names.size() != 0 || item_fifo.size() != 0)
            errors++;
        if (errors == 0)
            $display("symbol_range_lookup_unit verification clean");
        else
            $display("symbol_range_lookup_unit verification failed");
        $finish;
    end

endmodule
